### rtl/core/twfr_pkg.sv
// ----------------------------------------------------------------------------
// twfr_pkg - shared types and codes of the twist frame receiver
// Status codes, register indexes and the structs passed between stages.
// ----------------------------------------------------------------------------
package twfr_pkg;

   // frame header layout: start byte, type byte, size byte
   localparam int HDR_LEN = 3;
   // width of a frame length compare: size*4+4 with an 8-bit size
   localparam int LEN_W = 11;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TWIST_TYPE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_TYPE     = 2'd3;

   // reset values of the configuration registers
   localparam logic [7:0] RST_START_MARKER = 8'd115;
   localparam logic [7:0] RST_END_MARKER   = 8'd10;
   localparam logic [7:0] RST_TWIST_TYPE   = 8'd0;
   localparam logic [7:0] RST_CMD_TYPE     = 8'd1;

   // frame status codes
   localparam logic [2:0] ST_TWIST     = 3'd0;
   localparam logic [2:0] ST_CMD       = 3'd1;
   localparam logic [2:0] ST_BAD_START = 3'd2;
   localparam logic [2:0] ST_LEN       = 3'd3;
   localparam logic [2:0] ST_TYPE      = 3'd4;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] twist_type_code;
      logic [7:0] command_type_code;
   } twfr_cfg_type;

   typedef struct packed {
      logic [2:0]  frame_status;
      logic [31:0] twist_x_bits;
      logic [31:0] twist_y_bits;
      logic [31:0] twist_yaw_bits;
      logic [1:0]  words_loaded;
   } twfr_result_type;

endpackage

### rtl/core/twfr_in_reg.sv
// ----------------------------------------------------------------------------
// twfr_in_reg - input register of the twist frame receiver
// Holds one received byte until the frame stage consumes it.
// ----------------------------------------------------------------------------
module twfr_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   input  logic       go,
   output logic       req_stall,
   output logic       byte_vld,
   output logic [7:0] rx_byte
);
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff;
   logic       accept;

   // full and not draining this cycle: hold off the sender
   assign req_stall = vld_ff && !go;
   assign accept    = req_valid && !req_stall;
   assign vld_in    = accept || (vld_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_vld = vld_ff;
   assign rx_byte  = byte_ff;

endmodule

### rtl/core/twfr_frame.sv
// ----------------------------------------------------------------------------
// twfr_frame - frame collection and check stage
// Counts bytes, keeps header and payload bytes, checks a closed frame and
// loads the twist words.
// ----------------------------------------------------------------------------
module twfr_frame #(
   parameter int FRAME_LIMIT = 256,
   parameter int TWIST_WORDS = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  twfr_pkg::twfr_cfg_type   cfg,
   input  logic                     byte_vld,
   input  logic [7:0]               rx_byte,
   input  logic                     go,
   output logic                     closes,
   output twfr_pkg::twfr_result_type result
);
   import twfr_pkg::*;

   localparam int CntW = $clog2(FRAME_LIMIT);
   localparam int PayLen = TWIST_WORDS * 4;
   localparam logic [CntW:0] Limit = (CntW + 1)'(FRAME_LIMIT);

   logic [CntW-1:0]    byte_count_ff, byte_count_in;
   logic [7:0]         header_ff [HDR_LEN];
   logic [7:0]         header_in [HDR_LEN];
   logic [7:0]         payload_ff [PayLen];
   logic [31:0]        twist_ff [TWIST_WORDS];
   logic [31:0]        twist_in [TWIST_WORDS];
   logic [31:0]        word_pad [3];

   logic [CntW:0]      count;
   logic               at_limit;
   logic               is_end;
   logic [7:0]         size;
   logic [LEN_W-1:0]   expect_len;
   logic               len_ok;
   logic [2:0]         status;
   logic               load_twist;
   logic [7:0]         n_words;
   logic [1:0]         loaded;

   // byte count and frame close
   assign count    = {1'b0, byte_count_ff} + 1'b1;
   assign at_limit = (count >= Limit);
   assign is_end   = (rx_byte == cfg.end_marker);
   assign closes   = byte_vld && !at_limit && is_end;

   always_comb begin
      byte_count_in = byte_count_ff;
      if (byte_vld) begin
         if (at_limit || is_end) begin
            byte_count_in = '0;
         end else begin
            byte_count_in = count[CntW-1:0];
         end
      end
   end

   // header bytes with the current byte folded in, so a close sees it
   always_comb begin
      for (int k = 0; k < HDR_LEN; k++) begin
         header_in[k] = header_ff[k];
         if (byte_vld && (32'(byte_count_ff) == k)) begin
            header_in[k] = rx_byte;
         end
      end
   end

   // frame checks: start, then type, then length
   assign size       = header_in[2];
   assign expect_len = {1'b0, size, 2'b00} + LEN_W'(4);
   assign len_ok     = (LEN_W'(count) == expect_len);

   always_comb begin
      if (header_in[0] != cfg.start_marker) begin
         status = ST_BAD_START;
      end else if (header_in[1] == cfg.twist_type_code) begin
         status = len_ok ? ST_TWIST : ST_LEN;
      end else if (header_in[1] == cfg.command_type_code) begin
         status = len_ok ? ST_CMD : ST_LEN;
      end else begin
         status = ST_TYPE;
      end
   end

   assign load_twist = closes && (status == ST_TWIST);
   assign n_words    = (size < 8'(TWIST_WORDS)) ? size : 8'(TWIST_WORDS);
   assign loaded     = (n_words > 8'd3) ? 2'd3 : n_words[1:0];

   // twist word load, little-endian from the payload bytes
   always_comb begin
      for (int i = 0; i < TWIST_WORDS; i++) begin
         twist_in[i] = twist_ff[i];
         if (load_twist && (size > 8'(i))) begin
            twist_in[i] = {payload_ff[4*i+3], payload_ff[4*i+2],
                           payload_ff[4*i+1], payload_ff[4*i]};
         end
      end
   end

   // words without storage read as zero
   for (genvar k = 0; k < 3; k++) begin : g_pad
      if (k < TWIST_WORDS) begin : g_word
         assign word_pad[k] = twist_in[k];
      end else begin : g_zero
         assign word_pad[k] = '0;
      end
   end

   always_comb begin
      result.frame_status   = status;
      result.twist_x_bits   = word_pad[0];
      result.twist_y_bits   = word_pad[1];
      result.twist_yaw_bits = word_pad[2];
      result.words_loaded   = load_twist ? loaded : 2'd0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         for (int k = 0; k < HDR_LEN; k++) begin
            header_ff[k] <= '0;
         end
         for (int i = 0; i < TWIST_WORDS; i++) begin
            twist_ff[i] <= '0;
         end
      end else if (go) begin
         byte_count_ff <= byte_count_in;
         header_ff     <= header_in;
         twist_ff      <= twist_in;
      end
   end

   // payload shadow, only read after the current frame wrote it
   always_ff @(posedge clock) begin
      if (go) begin
         for (int j = 0; j < PayLen; j++) begin
            if (32'(byte_count_ff) == j + HDR_LEN) begin
               payload_ff[j] <= rx_byte;
            end
         end
      end
   end

endmodule

### rtl/core/twfr_out_reg.sv
// ----------------------------------------------------------------------------
// twfr_out_reg - result register of the twist frame receiver
// Holds one frame status until the consumer takes it.
// ----------------------------------------------------------------------------
module twfr_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  twfr_pkg::twfr_result_type result,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output twfr_pkg::twfr_result_type rsp_data
);
   import twfr_pkg::*;

   logic            vld_ff, vld_in;
   twfr_result_type data_ff;

   assign vld_in = load || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

### rtl/core/twist_frame_receiver.sv
// ----------------------------------------------------------------------------
// twist_frame_receiver - serial frame receiver for twist velocity frames
// Collects bytes into frames, checks each closed frame and reports a status
// with the stored twist words.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | req_rx_byte
//   rsp     | out       | rsp_valid/stall    | status, three twist words, count
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One byte per cycle is taken unless req_stall is high; a request goes
// through the input register and the frame stage into the result register,
// where a closing byte shows its result. Bytes that close no frame give no
// result and never wait on rsp.
// The stall from rsp reaches req_stall only when a closing byte is held.
// Synchronous reset clears counts, header bytes and twist words and loads the reset markers and type codes.
// ----------------------------------------------------------------------------
module twist_frame_receiver #(
   parameter int FRAME_LIMIT = 256,
   parameter int TWIST_WORDS = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_frame_status,
   output logic [31:0]                      rsp_twist_x_bits,
   output logic [31:0]                      rsp_twist_y_bits,
   output logic [31:0]                      rsp_twist_yaw_bits,
   output logic [1:0]                       rsp_words_loaded,
   input  logic                             csr_we,
   input  logic [twfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_wdata
);
   import twfr_pkg::*;

   twfr_cfg_type    cfg_ff;
   logic            byte_vld;
   logic [7:0]      rx_byte;
   logic            closes;
   logic            go;
   twfr_result_type result;
   twfr_result_type rsp_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker      <= RST_START_MARKER;
         cfg_ff.end_marker        <= RST_END_MARKER;
         cfg_ff.twist_type_code   <= RST_TWIST_TYPE;
         cfg_ff.command_type_code <= RST_CMD_TYPE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: cfg_ff.start_marker      <= csr_wdata;
            CSR_END_MARKER:   cfg_ff.end_marker        <= csr_wdata;
            CSR_TWIST_TYPE:   cfg_ff.twist_type_code   <= csr_wdata;
            CSR_CMD_TYPE:     cfg_ff.command_type_code <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a held byte moves on unless it closes a frame and rsp is blocked
   assign go = byte_vld && (!closes || !rsp_valid || !rsp_stall);

   twfr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .go          (go),
      .req_stall   (req_stall),
      .byte_vld    (byte_vld),
      .rx_byte     (rx_byte)
   );

   twfr_frame #(
      .FRAME_LIMIT (FRAME_LIMIT),
      .TWIST_WORDS (TWIST_WORDS)
   ) u_frame (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .byte_vld (byte_vld),
      .rx_byte  (rx_byte),
      .go       (go),
      .closes   (closes),
      .result   (result)
   );

   twfr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (go && closes),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_frame_status   = rsp_data.frame_status;
   assign rsp_twist_x_bits   = rsp_data.twist_x_bits;
   assign rsp_twist_y_bits   = rsp_data.twist_y_bits;
   assign rsp_twist_yaw_bits = rsp_data.twist_yaw_bits;
   assign rsp_words_loaded   = rsp_data.words_loaded;

endmodule

### rtl/core/twfr_checker.sv
// ----------------------------------------------------------------------------
// twfr_checker - port-level checks of the twist frame receiver
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module twfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_frame_status,
   input logic [31:0] rsp_twist_x_bits,
   input logic [1:0]  rsp_words_loaded
);
   import twfr_pkg::*;

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // only the defined status codes come out
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_status <= ST_TYPE))
      else $error("undefined frame status");

   // only a loaded twist frame reports updated words
   a_loaded_twist_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_status != ST_TWIST)) |-> (rsp_words_loaded == 2'd0))
      else $error("words loaded on a frame that loaded nothing");

   // a stalled result stays put
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_frame_status) && $stable(rsp_twist_x_bits)))
      else $error("stalled result changed");

endmodule

bind twist_frame_receiver twfr_checker u_twfr_checker (.*);
